// ===== hdl/modexp_pkg.sv =====
// Package: widths, datapath command and status types for the modular exponentiation core.
`timescale 1ns / 1ps
`default_nettype none

package modexp_pkg;

    localparam int BASE_W   = 32;
    localparam int EXP_W    = 32;
    localparam int MOD_W    = 31;
    localparam int WIDTH    = 32;
    localparam int EXP_BITS = (WIDTH < EXP_W) ? WIDTH : EXP_W;
    localparam int PROD_W   = 2 * MOD_W;
    localparam int RCNT_W   = $clog2(PROD_W + 1);

    typedef enum logic [1:0] {
        SEL_BASE  = 2'd0,
        SEL_ACCSQ = 2'd1,
        SEL_SQSQ  = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul;
        mul_sel_t mul_sel;
        logic     step;
        logic     wr_base;
        logic     wr_acc;
        logic     wr_sq;
    } dp_cmd_t;

    typedef struct packed {
        logic red_done;
        logic exp_lsb;
        logic exp_zero;
        logic mod_zero;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/modexp_dp.sv =====
// Datapath: operand registers, 31x31 multiplier and bit-serial modular reduction.
`timescale 1ns / 1ps
`default_nettype none

module modexp_dp
    import modexp_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [BASE_W-1:0]  s_base,
    input  wire logic [EXP_W-1:0]   s_exponent,
    input  wire logic [MOD_W-1:0]   s_modulus,
    input  wire dp_cmd_t            cmd,
    output dp_sts_t                 sts,
    output logic      [MOD_W-1:0]   residue
);

    logic [MOD_W-1:0]    mod_reg;
    logic [EXP_BITS-1:0] exp_reg;
    logic                neg_reg;
    logic [BASE_W-1:0]   mag_reg;
    logic [MOD_W-1:0]    acc_reg;
    logic [MOD_W-1:0]    sq_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [MOD_W-1:0]    rem_reg;
    logic [RCNT_W-1:0]   red_cnt_reg;

    logic [MOD_W-1:0]    mul_a;
    logic [MOD_W-1:0]    mul_b;
    logic [PROD_W-1:0]   prod_next;
    logic [MOD_W:0]      shifted;
    logic [MOD_W:0]      diff;
    logic [MOD_W-1:0]    rem_next;
    logic [MOD_W-1:0]    base_res;
    logic [BASE_W-1:0]   mag_in;

    assign mag_in = s_base[BASE_W-1] ? (~s_base + BASE_W'(1)) : s_base;

    always_comb begin
        mul_a = sq_reg;
        mul_b = sq_reg;
        unique case (cmd.mul_sel)
            SEL_ACCSQ: mul_a = acc_reg;
            SEL_SQSQ:  mul_a = sq_reg;
            default:   mul_a = sq_reg;
        endcase
        if (cmd.mul_sel == SEL_BASE) begin
            prod_next = PROD_W'(mag_reg);
        end else begin
            prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
        end
    end

    assign shifted  = {rem_reg, prod_reg[PROD_W-1]};
    assign diff     = shifted - {1'b0, mod_reg};
    assign rem_next = (shifted >= {1'b0, mod_reg}) ? diff[MOD_W-1:0] : shifted[MOD_W-1:0];
    assign base_res = (neg_reg && (rem_reg != '0)) ? (mod_reg - rem_reg) : rem_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mod_reg <= s_modulus;
            exp_reg <= s_exponent[EXP_BITS-1:0];
            neg_reg <= s_base[BASE_W-1];
            mag_reg <= mag_in;
            acc_reg <= (s_modulus > MOD_W'(1)) ? MOD_W'(1) : '0;
        end
        if (cmd.mul) begin
            prod_reg <= prod_next;
            rem_reg  <= '0;
        end else if (cmd.step) begin
            prod_reg <= {prod_reg[PROD_W-2:0], 1'b0};
            rem_reg  <= rem_next;
        end
        if (cmd.wr_base) begin
            sq_reg <= base_res;
        end
        if (cmd.wr_acc) begin
            acc_reg <= rem_reg;
        end
        if (cmd.wr_sq) begin
            sq_reg  <= rem_reg;
            exp_reg <= exp_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_cnt_reg <= '0;
        end else if (cmd.mul) begin
            red_cnt_reg <= '0;
        end else if (cmd.step) begin
            red_cnt_reg <= red_cnt_reg + RCNT_W'(1);
        end
    end

    assign sts.red_done = (red_cnt_reg == RCNT_W'(PROD_W));
    assign sts.exp_lsb  = exp_reg[0];
    assign sts.exp_zero = (exp_reg == '0);
    assign sts.mod_zero = (mod_reg == '0);
    assign residue      = acc_reg;

endmodule

`default_nettype wire

// ===== hdl/modexp_ctrl.sv =====
// Controller: sequences base reduction and square-and-multiply over the exponent bits.
`timescale 1ns / 1ps
`default_nettype none

module modexp_ctrl
    import modexp_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_BASE_MUL = 9'b000000010,
        ST_BASE_RED = 9'b000000100,
        ST_CHECK    = 9'b000001000,
        ST_ACC_MUL  = 9'b000010000,
        ST_ACC_RED  = 9'b000100000,
        ST_SQ_MUL   = 9'b001000000,
        ST_SQ_RED   = 9'b010000000,
        ST_OUT      = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = SEL_BASE;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) state_next = ST_BASE_MUL;
            end
            ST_BASE_MUL: begin
                cmd.mul     = 1'b1;
                cmd.mul_sel = SEL_BASE;
                state_next  = ST_BASE_RED;
            end
            ST_BASE_RED: begin
                if (sts.red_done) begin
                    cmd.wr_base = 1'b1;
                    state_next  = ST_CHECK;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_CHECK: begin
                priority if (sts.mod_zero || sts.exp_zero) state_next = ST_OUT;
                else if (sts.exp_lsb) state_next = ST_ACC_MUL;
                else state_next = ST_SQ_MUL;
            end
            ST_ACC_MUL: begin
                cmd.mul     = 1'b1;
                cmd.mul_sel = SEL_ACCSQ;
                state_next  = ST_ACC_RED;
            end
            ST_ACC_RED: begin
                if (sts.red_done) begin
                    cmd.wr_acc = 1'b1;
                    state_next = ST_SQ_MUL;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_SQ_MUL: begin
                cmd.mul     = 1'b1;
                cmd.mul_sel = SEL_SQSQ;
                state_next  = ST_SQ_RED;
            end
            ST_SQ_RED: begin
                if (sts.red_done) begin
                    cmd.wr_sq  = 1'b1;
                    state_next = ST_CHECK;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/modular_exponentiation_core.sv =====
// Top level: modular exponentiation core, base ^ exponent mod modulus.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  s_       | s_valid / s_ready  | s_base[31:0] signed, s_exponent[31:0], s_modulus[30:0]
//  m_       | m_valid / m_ready  | m_residue[30:0]
//
// One transaction at a time. The base is reduced first, then each exponent bit
// up to the highest set bit costs a check and a square, plus a multiply if the bit
// is set, each reduced by the bit-serial remainder unit (one product bit per cycle).
// Synchronous active-low reset returns the core to idle; a stalled result holds
// s_ready low until m_ready takes it.
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation_core
    import modexp_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [BASE_W-1:0]  s_base,
    input  wire logic [EXP_W-1:0]   s_exponent,
    input  wire logic [MOD_W-1:0]   s_modulus,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [MOD_W-1:0]   m_residue
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    modexp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    modexp_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_base     (s_base),
        .s_exponent (s_exponent),
        .s_modulus  (s_modulus),
        .cmd        (cmd),
        .sts        (sts),
        .residue    (m_residue)
    );

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted while a result is pending");

    a_accept_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid)
        else $error("result raised right after input transaction");

    a_mul_restarts_red: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul |=> !sts.red_done)
        else $error("reduction counter not restarted by multiply");

    a_step_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> !sts.red_done)
        else $error("reduction step past the last product bit");

endmodule

`default_nettype wire

// ===== dv/modular_exponentiation_core_chk.sv =====
// Checker for the modular exponentiation core: predicts each residue and compares the results.
`timescale 1ns / 1ps

module modular_exponentiation_core_chk
    import modexp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire logic [BASE_W-1:0] s_base,
    input  wire logic [EXP_W-1:0]  s_exponent,
    input  wire logic [MOD_W-1:0]  s_modulus,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire logic [MOD_W-1:0]  m_residue,
    output int unsigned            residues_owed,
    output int unsigned            mismatches
);

    typedef struct {
        logic [BASE_W-1:0] base;
        logic [EXP_W-1:0]  exponent;
        logic [MOD_W-1:0]  modulus;
        logic [MOD_W-1:0]  residue;
    } power_job_t;

    power_job_t  expected_powers[$];
    int unsigned owed_count = 0;
    int unsigned fail_count = 0;

    assign residues_owed = owed_count;
    assign mismatches    = fail_count;

    function automatic logic [MOD_W-1:0] modexp_residue(
        input logic [BASE_W-1:0] b,
        input logic [EXP_W-1:0]  e,
        input logic [MOD_W-1:0]  m
    );
        logic [63:0] mod64;
        logic [63:0] mag;
        logic [63:0] sq;
        logic [63:0] acc;
        if (m == '0)
            return '0;
        mod64 = {33'd0, m};
        if (b[BASE_W-1]) begin
            mag = {32'd0, (~b) + 32'd1};
            sq  = mag % mod64;
            if (sq != 64'd0)
                sq = mod64 - sq;
        end else begin
            sq = {32'd0, b} % mod64;
        end
        acc = 64'd1 % mod64;
        for (int i = 0; i < EXP_BITS; i++) begin
            if (e[i])
                acc = (acc * sq) % mod64;
            sq = (sq * sq) % mod64;
        end
        return acc[MOD_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input power_job_t job,
                                   input logic [MOD_W-1:0] got);
        $display("%0t: %s: base %0d exponent 0x%08h modulus %0d: expected %0d got %0d",
                 $realtime, what, $signed(job.base), job.exponent, job.modulus,
                 job.residue, got);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        power_job_t job;
        if (!aresetn) begin
            expected_powers.delete();
            owed_count = 0;
        end else begin
            // result side first so a same-edge transaction is never matched to itself
            if (m_valid && m_ready) begin
                if (expected_powers.size() == 0) begin
                    job = '{default: '0};
                    report_mismatch("unexpected residue", job, m_residue);
                end else begin
                    job = expected_powers.pop_front();
                    owed_count--;
                    if (m_residue !== job.residue)
                        report_mismatch("residue mismatch", job, m_residue);
                end
            end
            if (s_valid && s_ready) begin
                job.base     = s_base;
                job.exponent = s_exponent;
                job.modulus  = s_modulus;
                job.residue  = modexp_residue(s_base, s_exponent, s_modulus);
                expected_powers.push_back(job);
                owed_count++;
            end
        end
    end

endmodule

// ===== dv/modular_exponentiation_core_tb.sv =====
// Testbench top: drives operand transactions into the modular exponentiation core.
`timescale 1ns / 1ps

module modular_exponentiation_core_tb;
    import modexp_pkg::*;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [BASE_W-1:0] s_base;
    logic [EXP_W-1:0]  s_exponent;
    logic [MOD_W-1:0]  s_modulus;
    logic              m_valid;
    logic              m_ready;
    logic [MOD_W-1:0]  m_residue;
    int unsigned       residues_owed;
    int unsigned       mismatches;

    always #1 aclk = ~aclk;

    modular_exponentiation_core u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_base     (s_base),
        .s_exponent (s_exponent),
        .s_modulus  (s_modulus),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_residue  (m_residue)
    );

    modular_exponentiation_core_chk u_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_base        (s_base),
        .s_exponent    (s_exponent),
        .s_modulus     (s_modulus),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_residue     (m_residue),
        .residues_owed (residues_owed),
        .mismatches    (mismatches)
    );

    function automatic int unsigned idle_cycles();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 96)
            return $urandom_range(4, 20);
        else
            return $urandom_range(50, 300);
    endfunction

    task automatic send_operands(input logic [BASE_W-1:0] b, input logic [EXP_W-1:0] e,
                                 input logic [MOD_W-1:0] m);
        int unsigned gap;
        gap = idle_cycles();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_base     <= b;
        s_exponent <= e;
        s_modulus  <= m;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_residues();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (residues_owed != 0) @(posedge aclk);
    endtask

    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(200, 3000)) @(posedge aclk);
            else
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            if ($urandom_range(0, 3) != 0) begin
                m_ready <= 1'b0;
                repeat (idle_cycles() + 1) @(posedge aclk);
            end
        end
    end

    initial begin
        logic [BASE_W-1:0] b;
        logic [EXP_W-1:0]  e;
        logic [MOD_W-1:0]  m;
        int unsigned       nbits;
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_base     <= '0;
        s_exponent <= '0;
        s_modulus  <= 31'd1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero exponent, unit modulus, negative bases, field extremes
        send_operands(32'd0,          32'd0,          31'd1);
        send_operands(32'd5,          32'd0,          31'd7);
        send_operands(32'd0,          32'd0,          31'd2);
        send_operands(-32'sd1,        32'd3,          31'd7);
        send_operands(32'h8000_0000,  32'd1,          31'h7FFF_FFFF);
        send_operands(32'h7FFF_FFFF,  32'hFFFF_FFFF,  31'h7FFF_FFFF);
        send_operands(32'h8000_0000,  32'hFFFF_FFFF,  31'h7FFF_FFFF);
        send_operands(32'd12345,      32'hFFFF_FFFF,  31'd1);
        send_operands(32'd2,          32'd30,         31'h7FFF_FFFF);
        send_operands(32'd3,          32'h8000_0000,  31'd1000000007);
        send_operands(-32'sd7,        32'd5,          31'd13);
        send_operands(32'h7FFF_FFFF,  32'd2,          31'h7FFF_FFFE);
        send_operands(-32'sd1,        32'hFFFF_FFFF,  31'h7FFF_FFFF);
        send_operands(32'd0,          32'd5,          31'h4000_0000);
        send_operands(32'd6,          32'd1,          31'd3);
        send_operands(-32'sd9,        32'd2,          31'd9);
        send_operands(32'hFFFF_FFFF,  32'h5555_5555,  31'h2AAA_AAAB);
        send_operands(32'h5555_5555,  32'hAAAA_AAAA,  31'h5555_5555);
        drain_residues();

        for (int i = 0; i < 122; i++) begin
            case ($urandom_range(0, 7))
                0: b = 32'($urandom_range(0, 16)) - 32'd8;
                1: case ($urandom_range(0, 2))
                       0: b = 32'h8000_0000;
                       1: b = 32'h7FFF_FFFF;
                       default: b = 32'hFFFF_FFFF;
                   endcase
                default: b = $urandom;
            endcase
            nbits = $urandom_range(0, 32);
            if (nbits == 0)
                e = '0;
            else
                e = ($urandom >> (32 - nbits)) | (32'd1 << (nbits - 1));
            case ($urandom_range(0, 5))
                0: m = 31'($urandom_range(1, 16));
                1: m = 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
                default: m = 31'($urandom_range(1, 32'h7FFF_FFFF));
            endcase
            send_operands(b, e, m);
            if (i % 50 == 49)
                drain_residues();
        end

        drain_residues();
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("modular_exponentiation_core_tb: PASS");
        else
            $display("modular_exponentiation_core_tb: FAIL");
        $finish;
    end

    initial begin
        #6_000_000;
        $display("modular_exponentiation_core_tb: FAIL");
        $finish;
    end

endmodule
